[sv/rbdt_pkg.sv]
`timescale 1ns / 1ps

package rbdt_pkg;

    // Breathing curve, 0..255, one point per table entry
    localparam int CURVE_LEN = 21;
    localparam logic [7:0] CURVE [CURVE_LEN] = '{
        8'd0,   8'd2,   8'd7,   8'd15,  8'd27,  8'd41,  8'd58,  8'd76,  8'd96,  8'd117,
        8'd138, 8'd159, 8'd179, 8'd197, 8'd214, 8'd228, 8'd240, 8'd248, 8'd253, 8'd255,
        8'd255
    };
    // The curve reaches full scale at its twentieth point, which ends a ramp table
    localparam int CURVE_FULL_LEN = 20;

    localparam logic [15:0] TRANS_START = 16'd500;
    localparam logic [15:0] TRANS_MIN   = 16'd40;
    localparam logic [6:0]  SCALE_LOW   = 7'd11;
    localparam logic [6:0]  SCALE_FULL  = 7'd100;
    localparam logic [11:0] STEP_MAX    = 12'hFFF;
    localparam logic [4:0]  STEADY_COUNT = 5'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified request, handed from the front to the back
    typedef struct packed {
        logic [23:0] color_from;
        logic [23:0] color_to;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
        logic        ramp;
        logic [11:0] step_ms;
    } t_job;

endpackage

[sv/rgb_breathe_duty_table_generator_unit.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake                    Contents
// --------  ---  ---------------------------  ------------------------------------------
// s_axis    in   s_axis_tvalid/s_axis_tready  one request: colors, on/off/ramp times
// m_axis    out  m_axis_tvalid/m_axis_tready  one duty table entry per transfer
// apb       in   psel/penable/pwrite/pready   register 0 at address 0: low_power
//
// In the front a request passes through capture, blink adjust, step divide
// by a reciprocal multiply and hand-off. The back issues one table entry
// per cycle unless m_axis stalls, through a 7-stage duty pipeline. A request
// leaves the queue and yields 0 to 60 entries; the front works on the next
// request meanwhile. Reset is synchronous and clears only control state.
// A stall on m_axis freezes the whole duty pipeline; the two-entry request
// queue lets the front keep accepting until it fills.

module rgb_breathe_duty_table_generator_unit #(
    parameter int CURVE_POINTS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [23:0] color_from, [47:24] color_to, [63:48] on_time_ms,
    // [79:64] off_time_ms, [95:80] transition_ms
    input  logic [95:0] s_axis_tdata,
    // [0] kind
    input  logic [0:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] entry_index, [11:5] duty_percent, [16:12] entry_count,
    // [28:17] step_ms, [44:29] pause_low_ms, [60:45] pause_high_ms, [63:61] zero
    output logic [63:0] m_axis_tdata,
    // [1:0] channel
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rbdt_pkg::*;

    localparam logic [2:0] REG_LOW_POWER_ADDR = 3'd0;

    logic        r_low_power;

    logic        w_push;
    logic        w_full;
    logic        w_pop;
    logic        w_empty;
    t_job        w_job_in;
    t_job        w_job_out;

    logic [6:0]  w_duty;
    logic [4:0]  w_idx;
    logic [4:0]  w_count;
    logic [11:0] w_step;
    logic [15:0] w_pause_low;
    logic [15:0] w_pause_high;

    // Configuration: write on the access phase, read back the live value
    assign pready = 1'b1;
    assign prdata = (paddr == REG_LOW_POWER_ADDR) ? {31'd0, r_low_power} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_power <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr == REG_LOW_POWER_ADDR)) begin
            r_low_power <= pwdata[0];
        end
    end

    // Front: take the request, derive blink timing and step size
    rbdt_front #(
        .CURVE_POINTS (CURVE_POINTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_kind       (s_axis_tuser[0]),
        .i_color_from (s_axis_tdata[23:0]),
        .i_color_to   (s_axis_tdata[47:24]),
        .i_on_ms      (s_axis_tdata[63:48]),
        .i_off_ms     (s_axis_tdata[79:64]),
        .i_trans_ms   (s_axis_tdata[95:80]),
        .o_push       (w_push),
        .o_job        (w_job_in),
        .i_full       (w_full)
    );

    // Hold classified requests between front and back
    rbdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_empty (w_empty)
    );

    // Back: walk channels blue, green, red and emit their duty entries
    rbdt_back #(
        .CURVE_POINTS (CURVE_POINTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_low_power   (r_low_power),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .i_job         (w_job_out),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_channel     (m_axis_tuser),
        .o_entry_index (w_idx),
        .o_duty        (w_duty),
        .o_count       (w_count),
        .o_step        (w_step),
        .o_pause_low   (w_pause_low),
        .o_pause_high  (w_pause_high),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {3'd0, w_pause_high, w_pause_low, w_step, w_count, w_duty, w_idx};

endmodule

[sv/rbdt_front.sv]
`timescale 1ns / 1ps

module rbdt_front #(
    parameter int CURVE_POINTS = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [23:0]       i_color_from,
    input  logic [23:0]       i_color_to,
    input  logic [15:0]       i_on_ms,
    input  logic [15:0]       i_off_ms,
    input  logic [15:0]       i_trans_ms,
    output logic              o_push,
    output rbdt_pkg::t_job    o_job,
    input  logic              i_full
);
    import rbdt_pkg::*;

    localparam int RampCount = (CURVE_POINTS < CURVE_FULL_LEN) ? CURVE_POINTS : CURVE_FULL_LEN;
    localparam logic [16:0] RoundUp  = 17'(RampCount - 1);
    // Reciprocal of the ramp count, exact for every 17-bit dividend
    localparam int          DivShift  = 17 + $clog2(RampCount);
    localparam longint      RecipFull = ((longint'(1) << DivShift) + longint'(RampCount) - 1)
                                        / longint'(RampCount);
    localparam logic [18:0] Recip     = 19'(RecipFull);

    typedef enum logic [1:0] {S_IDLE, S_ADJUST, S_DIVIDE, S_PUSH} t_state;

    t_state      r_state;
    logic        r_kind;
    logic [23:0] r_from;
    logic [23:0] r_to;
    logic [15:0] r_on;
    logic [15:0] r_off;
    logic [15:0] r_trans;
    logic        r_ramp;
    logic [16:0] r_dvd;
    logic [16:0] r_quo;

    logic [15:0] n_on;
    logic [15:0] n_off;
    logic [15:0] n_trans;
    logic [15:0] w_a;
    logic [35:0] w_prod;
    logic [16:0] w_quo;
    logic [11:0] w_step;

    // Blink requests derive the ramp from the hold times
    always_comb begin
        w_a     = TRANS_START;
        n_on    = r_on;
        n_off   = r_off;
        n_trans = r_trans;
        if ((r_on != 16'd0) && (w_a > (r_on >> 1))) begin
            w_a = r_on >> 1;
        end
        if ((r_off != 16'd0) && (w_a > (r_off >> 1))) begin
            w_a = r_off >> 1;
        end
        if (!r_kind) begin
            if (((r_on == 16'd0) && (r_off == 16'd0)) || (w_a < TRANS_MIN)) begin
                n_trans = 16'd0;
            end else begin
                n_trans = w_a;
                if (r_on != 16'd0) begin
                    n_on = r_on - w_a;
                end
                if (r_off != 16'd0) begin
                    n_off = r_off - w_a;
                end
            end
        end
    end

    // Divide by the ramp count with one multiply by its scaled reciprocal
    assign w_prod = {19'd0, r_dvd} * {17'd0, Recip};
    assign w_quo  = 17'(w_prod >> DivShift);

    always_comb begin
        if (!r_ramp || (RampCount <= 2)) begin
            w_step = 12'd1;
        end else if (r_quo[16:12] != 5'd0) begin
            w_step = STEP_MAX;
        end else begin
            w_step = r_quo[11:0];
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_push  = (r_state == S_PUSH) && !i_full;

    always_comb begin
        o_job.color_from = r_from;
        o_job.color_to   = r_to;
        o_job.on_ms      = r_on;
        o_job.off_ms     = r_off;
        o_job.ramp       = r_ramp;
        o_job.step_ms    = w_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_kind;
                        r_from  <= i_kind ? i_color_from : 24'd0;
                        r_to    <= i_color_to;
                        r_on    <= i_on_ms;
                        r_off   <= i_off_ms;
                        r_trans <= i_trans_ms;
                        r_state <= S_ADJUST;
                    end
                end
                S_ADJUST: begin
                    r_on    <= n_on;
                    r_off   <= n_off;
                    r_trans <= n_trans;
                    r_ramp  <= (n_on != 16'd0) && (n_trans != 16'd0);
                    r_dvd   <= {1'b0, n_trans} + RoundUp;
                    r_state <= S_DIVIDE;
                end
                S_DIVIDE: begin
                    r_quo   <= w_quo;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/rbdt_queue.sv]
`timescale 1ns / 1ps

module rbdt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rbdt_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output rbdt_pkg::t_job o_data,
    output logic           o_empty
);
    import rbdt_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[sv/rbdt_back.sv]
`timescale 1ns / 1ps

module rbdt_back #(
    parameter int CURVE_POINTS = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_low_power,
    input  logic           i_empty,
    output logic           o_pop,
    input  rbdt_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_channel,
    output logic [4:0]     o_entry_index,
    output logic [6:0]     o_duty,
    output logic [4:0]     o_count,
    output logic [11:0]    o_step,
    output logic [15:0]    o_pause_low,
    output logic [15:0]    o_pause_high,
    output logic           o_last
);
    import rbdt_pkg::*;

    localparam int RampCount = (CURVE_POINTS < CURVE_FULL_LEN) ? CURVE_POINTS : CURVE_FULL_LEN;
    localparam logic [4:0]  RampCountV = 5'(RampCount);
    localparam int          Stages     = 7;
    localparam logic [1:0]  CH_RED     = 2'd0;
    localparam logic [1:0]  CH_GREEN   = 2'd1;
    localparam logic [1:0]  CH_BLUE    = 2'd2;
    // 254*255, turns the double divide by 255 into a rounded-up single one
    localparam logic [22:0] CEIL_BIAS  = 23'd64770;

    typedef struct packed {
        logic [1:0]  channel;
        logic [4:0]  idx;
        logic [4:0]  count;
        logic [11:0] step;
        logic [15:0] pause_low;
        logic [15:0] pause_high;
        logic        last;
    } t_meta;

    // floor(x/255) estimate by x*257/65536, at most one short
    function automatic logic [14:0] est255(input logic [22:0] x);
        logic [31:0] s;
        s = {1'b0, x, 8'd0} + {9'd0, x};
        return s[30:16];
    endfunction

    function automatic logic [14:0] fix255(input logic [22:0] x, input logic [14:0] q);
        logic [22:0] t;
        logic [22:0] r;
        t = {q, 8'd0} - {8'd0, q};
        r = x - t;
        return (r >= 23'd255) ? (q + 15'd1) : q;
    endfunction

    function automatic logic [7:0] byte_of(input logic [23:0] c, input logic [1:0] ch);
        logic [7:0] b;
        case (ch)
            CH_BLUE:  b = c[7:0];
            CH_GREEN: b = c[15:8];
            CH_RED:   b = c[23:16];
            default:  b = c[23:16];
        endcase
        return b;
    endfunction

    t_job        r_job;
    logic [2:0]  r_pend;
    logic [4:0]  r_idx;
    logic [Stages-1:0] r_vld;
    t_meta       r_meta [Stages];

    logic [7:0]  r_c1;
    logic [7:0]  r_c2;
    logic [7:0]  r_p;
    logic        r_steady0;
    logic [15:0] r_blend;
    logic        r_steady1;
    logic [22:0] r_x;
    logic [22:0] r_x3;
    logic [14:0] r_q1e;
    logic [14:0] r_q1;
    logic [14:0] r_q5;
    logic [6:0]  r_q2e;
    logic [6:0]  r_duty;

    logic        w_adv;
    logic [1:0]  w_ch;
    logic [2:0]  w_ch_bit;
    logic [2:0]  w_rest;
    logic [4:0]  w_count;
    logic        w_end;
    logic [7:0]  w_p;
    t_meta       w_meta;
    logic [6:0]  w_scale;
    logic [22:0] w_x;
    logic [14:0] w_q2e_full;
    logic [14:0] w_q2;

    assign w_adv = !r_vld[Stages-1] || i_ready;
    assign o_pop = (r_pend == 3'd0) && !i_empty;

    always_comb begin
        if (r_pend[2]) begin
            w_ch     = CH_BLUE;
            w_ch_bit = 3'b100;
        end else if (r_pend[1]) begin
            w_ch     = CH_GREEN;
            w_ch_bit = 3'b010;
        end else begin
            w_ch     = CH_RED;
            w_ch_bit = 3'b001;
        end
        w_rest  = r_pend & ~w_ch_bit;
        w_count = r_job.ramp ? RampCountV : STEADY_COUNT;
        w_end   = (r_idx == (w_count - 5'd1));
        if (r_job.ramp) begin
            w_p = CURVE[r_idx];
        end else begin
            w_p = (r_idx == 5'd0) ? 8'd0 : 8'd255;
        end
        w_meta.channel    = w_ch;
        w_meta.idx        = r_idx;
        w_meta.count      = w_count;
        w_meta.step       = r_job.step_ms;
        w_meta.pause_low  = r_job.off_ms;
        w_meta.pause_high = r_job.on_ms;
        w_meta.last       = w_end && (w_rest == 3'd0);
    end

    assign w_scale    = i_low_power ? SCALE_LOW : SCALE_FULL;
    assign w_x        = ({7'd0, r_blend} * {16'd0, w_scale}) + (r_steady1 ? CEIL_BIAS : 23'd0);
    assign w_q2e_full = est255({8'd0, r_q1});
    assign w_q2       = fix255({8'd0, r_q5}, {8'd0, r_q2e});

    // Sequencer and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'd0;
            r_idx  <= 5'd0;
            r_vld  <= '0;
        end else begin
            if (o_pop) begin
                r_job  <= i_job;
                r_pend <= {|i_job.color_to[7:0], |i_job.color_to[15:8],
                           |i_job.color_to[23:16]};
                r_idx  <= 5'd0;
            end else if (w_adv && (r_pend != 3'd0)) begin
                if (w_end) begin
                    r_idx  <= 5'd0;
                    r_pend <= w_rest;
                end else begin
                    r_idx <= r_idx + 5'd1;
                end
            end
            if (w_adv) begin
                r_vld <= {r_vld[Stages-2:0], (r_pend != 3'd0)};
            end
        end
    end

    // Duty datapath: blend, scale, two passes of divide by 255
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_meta[0] <= w_meta;
            for (int k = 1; k < Stages; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
            r_c1      <= byte_of(r_job.color_from, w_ch);
            r_c2      <= byte_of(r_job.color_to, w_ch);
            r_p       <= w_p;
            r_steady0 <= !r_job.ramp;
            r_blend   <= ({8'd0, r_c2} * {8'd0, r_p}) + ({8'd0, r_c1} * {8'd0, 8'd255 - r_p});
            r_steady1 <= r_steady0;
            r_x       <= w_x;
            r_x3      <= r_x;
            r_q1e     <= est255(r_x);
            r_q1      <= fix255(r_x3, r_q1e);
            r_q5      <= r_q1;
            r_q2e     <= w_q2e_full[6:0];
            r_duty    <= w_q2[6:0];
        end
    end

    assign o_valid       = r_vld[Stages-1];
    assign o_channel     = r_meta[Stages-1].channel;
    assign o_entry_index = r_meta[Stages-1].idx;
    assign o_duty        = r_duty;
    assign o_count       = r_meta[Stages-1].count;
    assign o_step        = r_meta[Stages-1].step;
    assign o_pause_low   = r_meta[Stages-1].pause_low;
    assign o_pause_high  = r_meta[Stages-1].pause_high;
    assign o_last        = r_meta[Stages-1].last;

endmodule
